@@ design/sca_pkg.sv @@
// Shared types, constants and codes for the slab cache allocator.
`timescale 1ns / 1ps
`default_nettype none
package sca_pkg;

  localparam int NUM_SLABS   = 16;
  localparam int MAX_ENTRIES = 256;
  localparam int SLAB_W      = $clog2(NUM_SLABS);
  localparam int ENT_W       = $clog2(MAX_ENTRIES);
  localparam int LINK_W      = SLAB_W + 1;
  localparam int CNT_W       = ENT_W + 1;
  localparam int HANDLE_W    = 12;
  localparam int CAP_W       = 9;

  localparam logic [CAP_W-1:0]  CAP_RESET = CAP_W'(64);
  localparam logic [CAP_W-1:0]  CAP_LOW   = CAP_W'(2);
  localparam logic [CAP_W-1:0]  CAP_HIGH  = CAP_W'(256);
  localparam logic [LINK_W-1:0] LINK_NIL  = LINK_W'(NUM_SLABS);
  localparam logic [CNT_W-1:0]  HEAD_NONE = CNT_W'(MAX_ENTRIES);

  typedef logic [1:0] class_t;
  localparam class_t CL_EMPTY   = 2'd0;
  localparam class_t CL_PARTIAL = 2'd1;
  localparam class_t CL_FULL    = 2'd2;
  localparam class_t CL_UNUSED  = 2'd3;

  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_FREE   = 2'd1;
  localparam logic [1:0] MODE_SHRINK = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_SLAB = 2'd1;
  localparam logic [1:0] ST_BAD     = 2'd2;

  typedef enum logic [3:0] {
    OP_NOP, OP_INIT, OP_UNLINK, OP_PUSH, OP_TAKE_FREE, OP_SET_HEAD,
    OP_TAKE_FRESH, OP_FREE, OP_SHRINK
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_CLAIM, S_UNLINK_E, S_PUSH_P, S_PICK, S_LINK, S_FULL_CHK,
    S_FREE_CHK, S_FREE_MOVE, S_MV_UNLINK, S_MV_PUSH, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t              op;
    class_t              push_class;
    logic                sel_we;
    logic [SLAB_W-1:0]   sel_d;
    logic                ent_we;
    logic [ENT_W-1:0]    ent_d;
  } dp_cmd_t;

  typedef struct packed {
    logic [LINK_W-1:0]   part_head;
    logic [LINK_W-1:0]   empty_head;
    logic                any_unused;
    logic [SLAB_W-1:0]   unused_idx;
    class_t              cls;
    logic [CNT_W-1:0]    fresh;
    logic [CNT_W-1:0]    used;
    logic [CNT_W-1:0]    cap;
    logic [SLAB_W-1:0]   sel;
    logic [ENT_W-1:0]    ent;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ design/sca_datapath.sv @@
// Slab tables, list links, entry link memory and their update operations.
`timescale 1ns / 1ps
`default_nettype none
module sca_datapath import sca_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [CAP_W-1:0] cfg_wr_data,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat
);

  logic [CNT_W-1:0]  free_head [NUM_SLABS];
  logic [CNT_W-1:0]  fresh     [NUM_SLABS];
  logic [CNT_W-1:0]  used      [NUM_SLABS];
  class_t            cls       [NUM_SLABS];
  logic [LINK_W-1:0] prv       [NUM_SLABS];
  logic [LINK_W-1:0] nxt       [NUM_SLABS];
  logic [LINK_W-1:0] list_head [3];
  logic [ENT_W-1:0]  link_mem  [NUM_SLABS*MAX_ENTRIES];
  logic [ENT_W-1:0]  link_rdata;
  logic [CAP_W-1:0]  capacity;
  logic [SLAB_W-1:0] sel;
  logic [ENT_W-1:0]  ent;
  logic [CNT_W-1:0]  cap_eff;
  logic              has_free;
  class_t            cur_cls;
  logic [LINK_W-1:0] p, n, h;

  always_comb begin
    if (capacity < CAP_LOW) cap_eff = CNT_W'(CAP_LOW);
    else if (capacity > CAP_HIGH) cap_eff = CNT_W'(CAP_HIGH);
    else cap_eff = CNT_W'(capacity);
  end

  assign cur_cls  = cls[sel];
  assign has_free = fresh[sel] > used[sel];
  assign p        = prv[sel];
  assign n        = nxt[sel];
  assign h        = list_head[cmd.push_class];

  always_comb begin
    stat.any_unused = 1'b0;
    stat.unused_idx = '0;
    for (int i = NUM_SLABS - 1; i >= 0; i--) begin
      if (cls[i] == CL_UNUSED) begin
        stat.any_unused = 1'b1;
        stat.unused_idx = SLAB_W'(i);
      end
    end
    stat.part_head  = list_head[CL_PARTIAL];
    stat.empty_head = list_head[CL_EMPTY];
    stat.cls        = cur_cls;
    stat.fresh      = fresh[sel];
    stat.used       = used[sel];
    stat.cap        = cap_eff;
    stat.sel        = sel;
    stat.ent        = ent;
  end

  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (cfg_wr_en) capacity <= cfg_wr_data;
  end

  // entry link memory: one read and one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == OP_FREE) begin
      link_mem[{sel, ent}] <= has_free ? free_head[sel][ENT_W-1:0] : '0;
    end
    link_rdata <= link_mem[{sel, free_head[sel][ENT_W-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (cmd.sel_we) sel <= cmd.sel_d;
    if (cmd.ent_we) ent <= cmd.ent_d;
    else if (cmd.op == OP_TAKE_FREE) ent <= free_head[sel][ENT_W-1:0];
    else if (cmd.op == OP_TAKE_FRESH) ent <= fresh[sel][ENT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SLABS; i++) begin
        free_head[i] <= HEAD_NONE;
        fresh[i]     <= '0;
        used[i]      <= '0;
        cls[i]       <= CL_UNUSED;
        prv[i]       <= LINK_NIL;
        nxt[i]       <= LINK_NIL;
      end
      for (int k = 0; k < 3; k++) list_head[k] <= LINK_NIL;
    end else begin
      case (cmd.op)
        OP_INIT: begin
          fresh[sel]     <= '0;
          used[sel]      <= '0;
          free_head[sel] <= HEAD_NONE;
        end
        OP_UNLINK: begin
          if (cur_cls != CL_UNUSED) begin
            if (!p[SLAB_W]) nxt[p[SLAB_W-1:0]] <= n;
            else list_head[cur_cls] <= n;
            if (!n[SLAB_W]) prv[n[SLAB_W-1:0]] <= p;
          end
          prv[sel] <= LINK_NIL;
          nxt[sel] <= LINK_NIL;
        end
        OP_PUSH: begin
          cls[sel] <= cmd.push_class;
          prv[sel] <= LINK_NIL;
          nxt[sel] <= h;
          if (!h[SLAB_W]) prv[h[SLAB_W-1:0]] <= {1'b0, sel};
          list_head[cmd.push_class] <= {1'b0, sel};
        end
        OP_TAKE_FREE: used[sel] <= used[sel] + 1'b1;
        OP_SET_HEAD: begin
          free_head[sel] <= has_free ? {1'b0, link_rdata} : HEAD_NONE;
        end
        OP_TAKE_FRESH: begin
          fresh[sel] <= fresh[sel] + 1'b1;
          used[sel]  <= used[sel] + 1'b1;
        end
        OP_FREE: begin
          free_head[sel] <= {1'b0, ent};
          used[sel]      <= used[sel] - 1'b1;
        end
        OP_SHRINK: begin
          for (int i = 0; i < NUM_SLABS; i++) begin
            if (cls[i] == CL_EMPTY) begin
              cls[i]       <= CL_UNUSED;
              prv[i]       <= LINK_NIL;
              nxt[i]       <= LINK_NIL;
              fresh[i]     <= '0;
              used[i]      <= '0;
              free_head[i] <= HEAD_NONE;
            end
          end
          list_head[CL_EMPTY] <= LINK_NIL;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/sca_ctrl.sv @@
// Request sequencer and result register for the slab cache allocator.
`timescale 1ns / 1ps
`default_nettype none
module sca_ctrl import sca_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          mode,
  input  wire logic [HANDLE_W-1:0] handle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [HANDLE_W-1:0]      result_handle,
  output dp_cmd_t                  cmd,
  input  wire dp_stat_t            stat
);

  state_t     state, state_next;
  logic [1:0] mode_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [1:0] stat_q, stat_q_next;
  logic       hit_q, hit_q_next;
  class_t     mv_class, mv_class_next;
  logic       out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mode_q   <= mode;
      handle_q <= handle;
    end
    stat_q   <= stat_q_next;
    hit_q    <= hit_q_next;
    mv_class <= mv_class_next;
    if (out_load) begin
      status        <= stat_q;
      result_handle <= hit_q ? HANDLE_W'({stat.sel, stat.ent}) : '0;
    end
  end

  always_comb begin
    state_next    = state;
    stat_q_next   = stat_q;
    hit_q_next    = hit_q;
    mv_class_next = mv_class;
    in_ready      = 1'b0;
    out_load      = 1'b0;
    cmd           = '0;
    cmd.op        = OP_NOP;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        stat_q_next = ST_OK;
        hit_q_next  = 1'b0;
        state_next  = S_DONE;
        case (mode_q)
          MODE_ALLOC: begin
            cmd.sel_we = 1'b1;
            if (!stat.part_head[SLAB_W]) begin
              cmd.sel_d  = stat.part_head[SLAB_W-1:0];
              state_next = S_PICK;
            end else if (!stat.empty_head[SLAB_W]) begin
              cmd.sel_d  = stat.empty_head[SLAB_W-1:0];
              state_next = S_UNLINK_E;
            end else if (stat.any_unused) begin
              cmd.sel_d  = stat.unused_idx;
              state_next = S_CLAIM;
            end else begin
              cmd.sel_we  = 1'b0;
              stat_q_next = ST_NO_SLAB;
            end
          end
          MODE_FREE: begin
            cmd.sel_we = 1'b1;
            cmd.sel_d  = handle_q[HANDLE_W-1:ENT_W];
            cmd.ent_we = 1'b1;
            cmd.ent_d  = handle_q[ENT_W-1:0];
            state_next = S_FREE_CHK;
          end
          MODE_SHRINK: cmd.op = OP_SHRINK;
          default: ;
        endcase
      end
      S_CLAIM: begin
        cmd.op     = OP_INIT;
        state_next = S_PUSH_P;
      end
      S_UNLINK_E: begin
        cmd.op     = OP_UNLINK;
        state_next = S_PUSH_P;
      end
      S_PUSH_P: begin
        cmd.op         = OP_PUSH;
        cmd.push_class = CL_PARTIAL;
        state_next     = S_PICK;
      end
      S_PICK: begin
        if (stat.fresh > stat.used) begin
          cmd.op     = OP_TAKE_FREE;
          state_next = S_LINK;
        end else if (stat.fresh < stat.cap) begin
          cmd.op     = OP_TAKE_FRESH;
          state_next = S_FULL_CHK;
        end else begin
          stat_q_next   = ST_NO_SLAB;
          mv_class_next = CL_FULL;
          state_next    = S_MV_UNLINK;
        end
      end
      S_LINK: begin
        cmd.op     = OP_SET_HEAD;
        state_next = S_FULL_CHK;
      end
      S_FULL_CHK: begin
        hit_q_next = 1'b1;
        if (stat.used >= stat.cap) begin
          mv_class_next = CL_FULL;
          state_next    = S_MV_UNLINK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE_CHK: begin
        if (stat.cls == CL_UNUSED || stat.cls == CL_EMPTY || stat.used == '0 ||
            {1'b0, stat.ent} >= stat.fresh) begin
          stat_q_next = ST_BAD;
          state_next  = S_DONE;
        end else begin
          cmd.op     = OP_FREE;
          state_next = S_FREE_MOVE;
        end
      end
      S_FREE_MOVE: begin
        if (stat.cls == CL_FULL) begin
          mv_class_next = CL_PARTIAL;
          state_next    = S_MV_UNLINK;
        end else if (stat.used == '0) begin
          mv_class_next = CL_EMPTY;
          state_next    = S_MV_UNLINK;
        end else begin
          state_next = S_DONE;
        end
      end
      S_MV_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = S_MV_PUSH;
      end
      S_MV_PUSH: begin
        cmd.op         = OP_PUSH;
        cmd.push_class = mv_class;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ design/slab_cache_allocator.sv @@
// Top level of the slab cache allocator: sequencer plus slab datapath.
//
//  channel | direction | handshake             | payload
//  in      | request   | in_valid / in_ready   | mode, handle
//  out     | result    | out_valid / out_ready | status, result_handle
//  cfg     | write     | cfg_wr_en             | cfg_wr_data (slab capacity)
//
// Each request runs as a sequence of slab-table updates, with a registered entry
// link read on the free-list path, between accept and result. One request is in
// flight at a time; the next is taken once the result sits in the output register,
// even while it still waits to be taken.
// Reset (rst, synchronous) empties every list and marks every slab unused.
// A stalled output holds the sequencer in its final state.
`timescale 1ns / 1ps
`default_nettype none
module slab_cache_allocator import sca_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          mode,
  input  wire logic [HANDLE_W-1:0] handle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [HANDLE_W-1:0]      result_handle,
  input  wire logic                cfg_wr_en,
  input  wire logic [CAP_W-1:0]    cfg_wr_data
);

  dp_cmd_t  cmd;
  dp_stat_t dstat;

  // sequence each request into table operations
  sca_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .mode, .handle,
    .out_valid, .out_ready, .status, .result_handle,
    .cmd, .stat(dstat)
  );

  // hold the slab tables, list links and entry link memory
  sca_datapath u_dp (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .cmd, .stat(dstat)
  );

endmodule
`default_nettype wire

@@ design/sca_checker.sv @@
// Port-level checks on the slab cache allocator, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none
module sca_checker import sca_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [1:0]          status,
  input wire logic [HANDLE_W-1:0] result_handle
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_OK || status == ST_NO_SLAB || status == ST_BAD)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> result_handle == '0)
    else $error("failed request carries a handle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(result_handle))
    else $error("stalled result changed");

endmodule

bind slab_cache_allocator sca_checker u_sca_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .status, .result_handle
);
`default_nettype wire

@@ bench/slab_cache_allocator_tb.sv @@
// Self-checking testbench for the slab cache allocator: random and directed requests, scoreboard.
`timescale 1ns / 1ps
module slab_cache_allocator_tb;
  import sca_pkg::*;

  // Mirror of the slab pool: predicts status and handle for every accepted request
  class slab_book;
    int link [NUM_SLABS*MAX_ENTRIES];
    int fhead [NUM_SLABS];
    int fresh [NUM_SLABS];
    int used [NUM_SLABS];
    int cls [NUM_SLABS];
    int prv [NUM_SLABS];
    int nxt [NUM_SLABS];
    int lhead [3];
    int cap_reg;
    int errors;
    logic [1:0] want_status [$];
    logic [HANDLE_W-1:0] want_handle [$];
    int live [$];

    function void clear();
      for (int s = 0; s < NUM_SLABS; s++) begin
        fhead[s] = MAX_ENTRIES;
        fresh[s] = 0;
        used[s] = 0;
        cls[s] = CL_UNUSED;
        prv[s] = NUM_SLABS;
        nxt[s] = NUM_SLABS;
      end
      for (int c = 0; c < 3; c++) lhead[c] = NUM_SLABS;
      cap_reg = CAP_RESET;
      errors = 0;
    endfunction

    function int eff_cap();
      int c;
      c = cap_reg;
      if (c < CAP_LOW) c = CAP_LOW;
      if (c > CAP_HIGH) c = CAP_HIGH;
      if (c > MAX_ENTRIES) c = MAX_ENTRIES;
      return c;
    endfunction

    function void unlink(int s);
      int p, n;
      p = prv[s];
      n = nxt[s];
      if (cls[s] != CL_UNUSED) begin
        if (p < NUM_SLABS) nxt[p] = n;
        else lhead[cls[s]] = n;
        if (n < NUM_SLABS) prv[n] = p;
      end
      prv[s] = NUM_SLABS;
      nxt[s] = NUM_SLABS;
    endfunction

    function void push(int c, int s);
      int h;
      h = lhead[c];
      cls[s] = c;
      prv[s] = NUM_SLABS;
      nxt[s] = h;
      if (h < NUM_SLABS) prv[h] = s;
      lhead[c] = s;
    endfunction

    function void move(int c, int s);
      unlink(s);
      push(c, s);
    endfunction

    function int take(output int hnd);
      int cap, s, e, i;
      cap = eff_cap();
      hnd = 0;
      s = lhead[CL_PARTIAL];
      if (s >= NUM_SLABS) begin
        s = lhead[CL_EMPTY];
        if (s < NUM_SLABS) move(CL_PARTIAL, s);
        else begin
          for (i = 0; i < NUM_SLABS; i++) if (cls[i] == CL_UNUSED) break;
          if (i >= NUM_SLABS) return ST_NO_SLAB;
          s = i;
          fresh[s] = 0;
          used[s] = 0;
          fhead[s] = MAX_ENTRIES;
          push(CL_PARTIAL, s);
        end
      end
      if (fresh[s] > used[s]) begin
        e = fhead[s] % MAX_ENTRIES;
        used[s]++;
        if (fresh[s] > used[s]) fhead[s] = link[s*MAX_ENTRIES+e] % MAX_ENTRIES;
        else fhead[s] = MAX_ENTRIES;
      end else if (fresh[s] < cap) begin
        e = fresh[s];
        fresh[s]++;
        used[s]++;
      end else begin
        move(CL_FULL, s);
        return ST_NO_SLAB;
      end
      if (used[s] >= cap) move(CL_FULL, s);
      hnd = (s*MAX_ENTRIES + e) & 12'hFFF;
      return ST_OK;
    endfunction

    function int give_back(int h);
      int s, e, c;
      s = h / MAX_ENTRIES;
      e = h % MAX_ENTRIES;
      if (s >= NUM_SLABS) return ST_BAD;
      c = cls[s];
      if (c == CL_UNUSED || c == CL_EMPTY) return ST_BAD;
      if (used[s] == 0 || e >= fresh[s]) return ST_BAD;
      link[s*MAX_ENTRIES+e] = (fresh[s] > used[s]) ? fhead[s] : 0;
      fhead[s] = e;
      used[s]--;
      if (c == CL_FULL) move(CL_PARTIAL, s);
      else if (used[s] == 0) move(CL_EMPTY, s);
      return ST_OK;
    endfunction

    function void shrink();
      for (int s = 0; s < NUM_SLABS; s++)
        if (cls[s] == CL_EMPTY) begin
          cls[s] = CL_UNUSED;
          prv[s] = NUM_SLABS;
          nxt[s] = NUM_SLABS;
          fresh[s] = 0;
          used[s] = 0;
          fhead[s] = MAX_ENTRIES;
        end
      lhead[CL_EMPTY] = NUM_SLABS;
    endfunction

    function void note_request(logic [1:0] m, logic [HANDLE_W-1:0] h);
      int st, hnd;
      st = ST_OK;
      hnd = 0;
      if (m == MODE_ALLOC) begin
        st = take(hnd);
        if (st == ST_OK) live.push_back(hnd);
      end else if (m == MODE_FREE) begin
        st = give_back(h);
        if (st == ST_OK)
          foreach (live[i]) if (live[i] == h) begin
            live.delete(i);
            break;
          end
      end else if (m == MODE_SHRINK) shrink();
      if (st != ST_OK) hnd = 0;
      want_status.push_back(st[1:0]);
      want_handle.push_back(hnd[HANDLE_W-1:0]);
    endfunction

    function void check_result(logic [1:0] st, logic [HANDLE_W-1:0] h);
      logic [1:0] ws;
      logic [HANDLE_W-1:0] wh;
      if (want_status.size() == 0) begin
        $display("%0t: unexpected result status %0d handle %0d", $time, st, h);
        errors++;
        return;
      end
      ws = want_status.pop_front();
      wh = want_handle.pop_front();
      if (st !== ws) begin
        $display("%0t: status expected %0d actual %0d", $time, ws, st);
        errors++;
      end
      if (h !== wh) begin
        $display("%0t: result_handle expected %0d actual %0d", $time, wh, h);
        errors++;
      end
    endfunction

    function int pending();
      return want_status.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] req_mode = MODE_ALLOC;
  logic [HANDLE_W-1:0] req_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [HANDLE_W-1:0] result_handle;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;

  slab_book book = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  slab_cache_allocator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(req_mode), .handle(req_handle),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .result_handle(result_handle),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off when asked for
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Check every result taken from the output channel
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_result(status, result_handle);
  end

  // Offer one request; hold it until accepted, then note it in the book.
  // Valid is only lowered when a gap follows, so it never toggles within one step.
  task automatic send_request(input logic [1:0] m, input logic [HANDLE_W-1:0] h);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_mode <= m;
    req_handle <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_request(m, h);
  endtask

  // Let every outstanding result drain, then write the capacity register
  task automatic set_capacity(input logic [CAP_W-1:0] v);
    in_valid <= 1'b0;
    while (book.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    book.cap_reg = v;
  endtask

  // Random request: mostly allocs and frees of live handles, some noise
  task automatic random_request();
    int r;
    logic [HANDLE_W-1:0] h;
    r = $urandom_range(99);
    h = HANDLE_W'($urandom_range(4095));
    if (r < 50) send_request(MODE_ALLOC, h);
    else if (r < 85 && book.live.size() > 0)
      send_request(MODE_FREE,
                   HANDLE_W'(book.live[$urandom_range(book.live.size()-1)]));
    else if (r < 93) send_request(MODE_FREE, h);
    else if (r < 97) send_request(MODE_SHRINK, h);
    else send_request(2'd3, h);
  endtask

  initial begin
    logic [CAP_W-1:0] caps [7];
    caps = '{9'd2, 9'd256, 9'd511, 9'd0, 9'd1, 9'd64, 9'd0};
    caps[6] = CAP_W'($urandom_range(511));
    book.clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reuse, double free, bad frees, unknown mode, shrink
    set_capacity(9'd64);
    repeat (3) send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 12'd1);
    send_request(MODE_FREE, 12'd1);      // double free pushes the entry again
    send_request(MODE_ALLOC, '0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, 12'h0FF);    // entry not handed out yet
    send_request(MODE_FREE, 12'hF00);    // unused slab
    send_request(2'd3, 12'hFFF);         // unknown mode is ignored
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_FREE, 12'd1);
    send_request(MODE_FREE, 12'd2);
    send_request(MODE_SHRINK, 12'hFFF);
    send_request(MODE_FREE, 12'd0);
    send_request(MODE_ALLOC, '0);
    send_request(MODE_FREE, HANDLE_W'(book.live[book.live.size()-1]));
    send_request(MODE_FREE, 12'd0);      // free into an empty slab
    repeat (4) send_request(MODE_ALLOC, '0);
    set_capacity(9'd2);
    send_request(MODE_ALLOC, '0);        // partial slab exhausted by lower capacity

    // Random phases over several capacities and idling patterns
    for (int p = 0; p < 7; p++) begin
      set_capacity(caps[p]);
      case (p % 3)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 74;
        end
        1: begin
          send_idle_pct = 74;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (p == 2) hold_left = 400;       // fill the block and stall its input
      repeat (215) random_request();
    end

    in_valid <= 1'b0;
    while (book.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) $display("slab_cache_allocator regression: pass");
    else $display("slab_cache_allocator regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("slab_cache_allocator regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
design/sca_pkg.sv
design/sca_datapath.sv
design/sca_ctrl.sv
design/slab_cache_allocator.sv
design/sca_checker.sv
bench/slab_cache_allocator_tb.sv
